@@ sv/ssw_pkg.sv @@
// Shared constants, types and the segment decoder for the stopwatch display block.
// No dependencies; every other file of the block but ssw_tick_if imports this package.
package ssw_pkg;

	// Display geometry
	localparam int NUM_DIGITS = 4;
	localparam int SCAN_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int DIGIT_W    = 4;
	localparam int SEG_W      = 7;
	localparam int EN_W       = 4;

	// Tick counter and limit register
	localparam int                LIMIT_W     = 14;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd9990;

	// Decimal digit codes
	localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 4'd0;
	localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;

	// Segment code for anything that is not a decimal digit: all segments dark
	localparam logic [SEG_W-1:0] SEG_BLANK = 7'h7F;

	// Controls sent from the tick logic to the digit chain
	typedef struct packed {
		logic load;  // an item is accepted this cycle
		logic clear; // all digits go to zero before the increment
		logic inc;   // bump the decade counter
	} ssw_chain_ctl_t;

	// Active-low common-anode segments g..a for one digit
	function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] seg;
		case (d)
			4'd0:    seg = 7'b1000000;
			4'd1:    seg = 7'b1111001;
			4'd2:    seg = 7'b0100100;
			4'd3:    seg = 7'b0110000;
			4'd4:    seg = 7'b0011001;
			4'd5:    seg = 7'b0010010;
			4'd6:    seg = 7'b0000010;
			4'd7:    seg = 7'b1111000;
			4'd8:    seg = 7'b0000000;
			4'd9:    seg = 7'b0010000;
			default: seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

endpackage

@@ sv/ssw_tick_if.sv @@
// Input channel: one millisecond tick item carrying the sampled button level.
// Does not depend on ssw_pkg; the payload is a single bit.
interface ssw_tick_if;
	logic valid;
	logic ready;
	logic button_level;

	modport source (output valid, output button_level, input ready);
	modport sink   (input valid, input button_level, output ready);
endinterface

@@ sv/ssw_result_if.sv @@
// Output channel: one display item per tick (segments, digit enable, status flags).
// Depends on ssw_pkg for the field widths.
interface ssw_result_if;
	import ssw_pkg::*;

	logic             valid;
	logic             ready;
	logic [SEG_W-1:0] segments;
	logic [EN_W-1:0]  digit_enable;
	logic             done_led;
	logic             running;

	modport source (output valid, output segments, output digit_enable,
		output done_led, output running, input ready);
	modport sink   (input valid, input segments, input digit_enable,
		input done_led, input running, output ready);
endinterface

@@ sv/ssw_digit_cell.sv @@
// One decade of the ripple BCD counter: holds a digit and passes its carry on.
// Depends on ssw_pkg.
module ssw_digit_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ssw_pkg::ssw_chain_ctl_t ctl,
	input  logic                    carry_in,
	output logic                    carry_out,
	output logic [ssw_pkg::DIGIT_W-1:0] digit_next
);
	import ssw_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] base;

	// Clear first, then increment; anything at nine or above rolls to zero
	always_comb begin
		base = ctl.clear ? DIGIT_ZERO : digit_q;
		carry_out = carry_in && (base >= DIGIT_NINE);
		if (!carry_in) begin
			digit_next = base;
		end else if (base >= DIGIT_NINE) begin
			digit_next = DIGIT_ZERO;
		end else begin
			digit_next = base + DIGIT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= DIGIT_ZERO;
		end else if (ctl.load) begin
			digit_q <= digit_next;
		end
	end
endmodule

@@ sv/ssw_digit_chain.sv @@
// Row of decade cells forming the shown count, plus the scan select of one digit.
// Depends on ssw_pkg and ssw_digit_cell.
module ssw_digit_chain (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ssw_pkg::ssw_chain_ctl_t     ctl,
	input  logic [ssw_pkg::SCAN_W-1:0]  sel,
	output logic [ssw_pkg::DIGIT_W-1:0] shown
);
	import ssw_pkg::*;

	logic [NUM_DIGITS:0]  carry;
	logic [DIGIT_W-1:0]   digit_next [NUM_DIGITS];

	// Carry enters at the least significant digit
	assign carry[0] = ctl.inc;

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		ssw_digit_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.carry_in   (carry[i]),
			.carry_out  (carry[i+1]),
			.digit_next (digit_next[i])
		);
	end

	// Scanned digit taken from the updated count
	assign shown = digit_next[sel];
endmodule

@@ sv/stopwatch_seven_segment_scan.sv @@
// Stopwatch with a multiplexed four-digit seven-segment display.
// Depends on ssw_pkg, ssw_tick_if, ssw_result_if and ssw_digit_chain.
//
// Each accepted tick item is one millisecond with the sampled button level. A falling
// edge of the button starts the count from zero when stopped and stops it (digits
// blanked to zero) when running; reaching count_limit stops the count, zeroes the
// digits and lights done_led until the next start. Every tick produces exactly one
// display item: the active-low segments and one-hot enable of the next scanned digit.
// One item is taken per clock cycle unless the output stalls; the result sits in an
// output register in the cycle after the tick, and a new tick is accepted whenever
// that register is empty or is being drained in the same cycle. count_limit is written
// through limit_we/limit_wdata and resets to 9990.
module stopwatch_seven_segment_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        limit_we,
	input  logic [ssw_pkg::LIMIT_W-1:0] limit_wdata,
	ssw_tick_if.sink                    tick,
	ssw_result_if.source                result
);
	import ssw_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic [LIMIT_W-1:0] tick_count_q;
	logic               button_prev_q;
	logic               run_q;
	logic               led_q;
	logic [SCAN_W-1:0]  scan_q;
	logic               out_valid_q;
	logic [SEG_W-1:0]   segments_q;
	logic [EN_W-1:0]    enable_q;
	logic               done_q;
	logic               running_q;

	logic               accept;
	logic               limit_hit;
	logic               run_lim;
	logic               led_lim;
	logic               fall;
	logic               start;
	logic               stop;
	logic               run_next;
	logic               led_next;
	logic [LIMIT_W-1:0] tick_next;
	logic [SCAN_W-1:0]  scan_next;
	logic [EN_W-1:0]    enable_next;
	logic [DIGIT_W-1:0] shown;
	ssw_chain_ctl_t     chain_ctl;

	// Handshake: output register is free or drains this cycle
	assign tick.ready = !out_valid_q || result.ready;
	assign accept     = tick.valid && tick.ready;

	// Limit check, then button edge, then count
	always_comb begin
		limit_hit = tick_count_q >= limit_q;
		run_lim   = limit_hit ? 1'b0 : run_q;
		led_lim   = limit_hit ? 1'b1 : led_q;
		fall      = button_prev_q && !tick.button_level;
		start     = fall && !run_lim;
		stop      = fall && run_lim;
		run_next  = start ? 1'b1 : (stop ? 1'b0 : run_lim);
		led_next  = start ? 1'b0 : led_lim;
		tick_next = start ? '0 : tick_count_q;
		if (run_next) begin
			tick_next = tick_next + LIMIT_W'(1);
		end
		chain_ctl.load  = accept;
		chain_ctl.clear = limit_hit || stop;
		chain_ctl.inc   = run_next;
	end

	ssw_digit_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (chain_ctl),
		.sel    (scan_q),
		.shown  (shown)
	);

	// Scan position and its one-hot enable
	always_comb begin
		if (scan_q == SCAN_W'(NUM_DIGITS - 1)) begin
			scan_next = '0;
		end else begin
			scan_next = scan_q + SCAN_W'(1);
		end
		enable_next = '0;
		if (32'(scan_q) < EN_W) begin
			enable_next = EN_W'(1) << scan_q;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	// Stopwatch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q  <= '0;
			button_prev_q <= 1'b0;
			run_q         <= 1'b0;
			led_q         <= 1'b0;
			scan_q        <= '0;
		end else if (accept) begin
			tick_count_q  <= tick_next;
			button_prev_q <= tick.button_level;
			run_q         <= run_next;
			led_q         <= led_next;
			scan_q        <= scan_next;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			segments_q <= seg_decode(shown);
			enable_q   <= enable_next;
			done_q     <= led_next;
			running_q  <= run_next;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.segments     = segments_q;
	assign result.digit_enable = enable_q;
	assign result.done_led     = done_q;
	assign result.running      = running_q;
endmodule
